@@ hw/rtl/par_pkg.sv @@
// ----------------------------------------------------------------------------
// par_pkg
// Shared types, constants and predictor functions of the adaptive row filter.
// ----------------------------------------------------------------------------
`default_nettype none

package par_pkg;

  localparam int MAX_ROW_BYTES   = 4096;
  localparam int MAX_PIXEL_BYTES = 8;
  localparam int FILTER_COUNT    = 5;
  localparam int COL_W           = $clog2(MAX_ROW_BYTES);
  localparam int ROW_BYTES_W     = 13;
  localparam int PIXEL_BYTES_W   = 4;
  localparam int IMAGE_ROWS_W    = 16;
  localparam int CFG_DATA_W      = 16;
  localparam int PB_IDX_W        = $clog2(MAX_PIXEL_BYTES);
  localparam int COST_W          = 20;
  localparam int QUEUE_DEPTH     = 8;
  localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W     = QUEUE_PTR_W + 1;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  typedef enum logic [1:0] {
    REG_ROW_BYTES   = 2'd0,
    REG_PIXEL_BYTES = 2'd1,
    REG_IMAGE_ROWS  = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_t;

  typedef struct packed {
    logic       command;
    logic [7:0] pixel_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_type_byte;
    logic       row_end;
  } out_item_t;

  typedef struct packed {
    logic      v0;
    logic      v1;
    out_item_t e0;
    out_item_t e1;
  } push_t;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [7:0] paeth(input logic [7:0] l, input logic [7:0] u,
                                       input logic [7:0] ul);
    logic signed [10:0] pa, pb, pc;
    pa = $signed({3'b0, u}) - $signed({3'b0, ul});
    pb = $signed({3'b0, l}) - $signed({3'b0, ul});
    pc = $signed({3'b0, l}) + $signed({3'b0, u}) - $signed({2'b0, ul, 1'b0});
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) paeth = l;
    else if (pb <= pc) paeth = u;
    else paeth = ul;
  endfunction

  function automatic logic [7:0] predict(input filt_t f, input logic [7:0] l,
                                         input logic [7:0] u, input logic [7:0] ul);
    logic [8:0] s;
    s = {1'b0, l} + {1'b0, u};
    case (f)
      FILT_SUB:   predict = l;
      FILT_UP:    predict = u;
      FILT_AVG:   predict = s[8:1];
      FILT_PAETH: predict = paeth(l, u, ul);
      default:    predict = 8'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/par_if.sv @@
// ----------------------------------------------------------------------------
// par_in_if / par_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface par_in_if import par_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface par_out_if import par_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/png_adaptive_row_filter.sv @@
// ----------------------------------------------------------------------------
// png_adaptive_row_filter
// Streaming PNG row filter: picks the cheapest of five filters per row and
// emits the filtered row one row behind its input.
// ----------------------------------------------------------------------------
//  channel     dir  handshake      payload
//  pixel_in    in   valid/ready    command, pixel_byte
//  result_out  out  valid/ready    out_byte, is_type_byte, row_end
//  cfg         in   cfg_we         cfg_index, cfg_data
//
//  One item per cycle when not stalled; results pass the stage registers and
//  the result queue. Line store reads are registered, so costs and residuals
//  are formed in the cycle after the transfer. The first item after a row
//  ends emits the type byte and, if a pixel, the first residual. pixel_in
//  stalls while the eight-entry result queue plus work in flight could not
//  take two more results. Synchronous reset; line stores are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module png_adaptive_row_filter import par_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  par_in_if.sink                     pixel_in,
  par_out_if.source                  result_out
);

  logic [ROW_BYTES_W-1:0]   row_bytes;
  logic [PIXEL_BYTES_W-1:0] pixel_bytes;
  logic [IMAGE_ROWS_W-1:0]  image_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes   <= ROW_BYTES_W'(1024);
      pixel_bytes <= PIXEL_BYTES_W'(4);
      image_rows  <= IMAGE_ROWS_W'(1);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ROW_BYTES:   row_bytes   <= cfg_data[ROW_BYTES_W-1:0];
        REG_PIXEL_BYTES: pixel_bytes <= cfg_data[PIXEL_BYTES_W-1:0];
        REG_IMAGE_ROWS:  image_rows  <= cfg_data[IMAGE_ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  logic [ROW_BYTES_W-1:0]   eff_rb;
  logic [PIXEL_BYTES_W-1:0] eff_pb;
  logic [IMAGE_ROWS_W-1:0]  eff_rows;
  logic [PB_IDX_W-1:0]      pbi;

  always_comb begin
    if (row_bytes == '0) eff_rb = ROW_BYTES_W'(1);
    else if (row_bytes > ROW_BYTES_W'(MAX_ROW_BYTES)) eff_rb = ROW_BYTES_W'(MAX_ROW_BYTES);
    else eff_rb = row_bytes;
    if (pixel_bytes == '0) eff_pb = PIXEL_BYTES_W'(1);
    else if (pixel_bytes > PIXEL_BYTES_W'(MAX_PIXEL_BYTES))
      eff_pb = PIXEL_BYTES_W'(MAX_PIXEL_BYTES);
    else eff_pb = pixel_bytes;
    eff_rows = (image_rows == '0) ? IMAGE_ROWS_W'(1) : image_rows;
  end

  assign pbi = PB_IDX_W'(eff_pb - PIXEL_BYTES_W'(1));

  // control state
  logic [COL_W-1:0]        col;
  logic [IMAGE_ROWS_W-1:0] row_pos;
  logic [1:0]              rot;
  logic                    pend_valid;
  logic                    pend_top;
  logic [ROW_BYTES_W-1:0]  emit_pos;
  filt_t                   pend_type;

  logic [COL_W-1:0]        col_next;
  logic [IMAGE_ROWS_W-1:0] row_pos_next;
  logic [1:0]              rot_next;
  logic                    pend_valid_next;
  logic                    pend_top_next;
  logic [ROW_BYTES_W-1:0]  emit_pos_next;

  logic                   acc;
  logic                   is_pixel;
  logic                   e_type;
  logic                   e_res;
  logic [ROW_BYTES_W-1:0] e_pos;
  logic [COL_W-1:0]       e_idx;
  logic                   e_end;
  logic                   row_done;
  logic [ROW_BYTES_W-1:0] col_inc;

  logic [QUEUE_CNT_W-1:0] q_count;
  logic                   s1_data;
  logic                   s1_type;
  logic                   s1_res;

  assign pixel_in.ready = (q_count + QUEUE_CNT_W'(s1_type) + QUEUE_CNT_W'(s1_res))
                          <= QUEUE_CNT_W'(QUEUE_DEPTH - 2);
  assign acc      = pixel_in.valid & pixel_in.ready;
  assign is_pixel = (cmd_t'(pixel_in.data.command) == CMD_PIXEL);
  assign col_inc  = ROW_BYTES_W'(col) + ROW_BYTES_W'(1);
  assign row_done = acc & is_pixel & (col_inc >= eff_rb);

  always_comb begin
    col_next        = col;
    row_pos_next    = row_pos;
    rot_next        = rot;
    pend_valid_next = pend_valid;
    pend_top_next   = pend_top;
    emit_pos_next   = emit_pos;
    e_type = acc & pend_valid & (emit_pos == '0);
    e_res  = acc & pend_valid & ((emit_pos != '0) | is_pixel);
    e_pos  = (emit_pos == '0) ? ROW_BYTES_W'(1) : emit_pos;
    e_idx  = COL_W'(e_pos - ROW_BYTES_W'(1));
    e_end  = (e_pos >= eff_rb);
    if (e_type && !e_res) begin
      emit_pos_next = ROW_BYTES_W'(1);
    end else if (e_res) begin
      if (e_end) begin
        pend_valid_next = 1'b0;
        emit_pos_next   = '0;
      end else begin
        emit_pos_next = e_pos + ROW_BYTES_W'(1);
      end
    end
    if (acc && is_pixel) begin
      if (row_done) begin
        pend_valid_next = 1'b1;
        pend_top_next   = (row_pos == '0);
        emit_pos_next   = '0;
        col_next        = '0;
        rot_next        = (rot == 2'd2) ? 2'd0 : rot + 2'd1;
        row_pos_next    = (IMAGE_ROWS_W'(row_pos + IMAGE_ROWS_W'(1)) >= eff_rows) ?
                          '0 : row_pos + IMAGE_ROWS_W'(1);
      end else begin
        col_next = col_inc[COL_W-1:0];
      end
    end
  end

  // store roles: current row at rot, row above pending at rot+1, pending at rot+2
  logic [1:0] pend_sel;
  logic [1:0] above_sel;
  assign pend_sel  = (rot == 2'd0) ? 2'd2 : rot - 2'd1;
  assign above_sel = (rot == 2'd2) ? 2'd0 : rot + 2'd1;

  logic [7:0] rd_a [3];
  logic [7:0] rd_b [3];

  for (genvar g = 0; g < 3; g++) begin : g_store
    par_ram #(.WIDTH(8), .DEPTH(MAX_ROW_BYTES)) u_store (
      .clk     (clk),
      .we      (acc & is_pixel & (rot == 2'(g))),
      .waddr   (col),
      .wdata   (pixel_in.data.pixel_byte),
      .raddr_a (col),
      .rdata_a (rd_a[g]),
      .raddr_b (e_idx),
      .rdata_b (rd_b[g])
    );
  end

  // recent data bytes of the current row for the left neighbor
  logic [7:0] dhist [MAX_PIXEL_BYTES];
  logic [7:0] l_in;
  assign l_in = (ROW_BYTES_W'(col) >= ROW_BYTES_W'(eff_pb)) ? dhist[pbi] : 8'd0;

  always_ff @(posedge clk) begin
    if (acc && is_pixel) begin
      dhist[0] <= pixel_in.data.pixel_byte;
      for (int j = 1; j < MAX_PIXEL_BYTES; j++) begin
        dhist[j] <= dhist[j-1];
      end
    end
  end

  // compute stage registers
  logic [7:0] s1_x;
  logic [7:0] s1_l;
  logic       s1_left_ok;
  logic       s1_top;
  logic       s1_last;
  logic [1:0] s1_pend_sel;
  logic [1:0] s1_above_sel;
  logic       s1_res_left_ok;
  logic       s1_res_top;
  logic       s1_res_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row_pos    <= '0;
      rot        <= '0;
      pend_valid <= 1'b0;
      pend_top   <= 1'b0;
      emit_pos   <= '0;
      s1_data    <= 1'b0;
      s1_type    <= 1'b0;
      s1_res     <= 1'b0;
    end else begin
      col        <= col_next;
      row_pos    <= row_pos_next;
      rot        <= rot_next;
      pend_valid <= pend_valid_next;
      pend_top   <= pend_top_next;
      emit_pos   <= emit_pos_next;
      s1_data    <= acc & is_pixel;
      s1_type    <= e_type;
      s1_res     <= e_res;
    end
  end

  always_ff @(posedge clk) begin
    s1_x           <= pixel_in.data.pixel_byte;
    s1_l           <= l_in;
    s1_left_ok     <= (ROW_BYTES_W'(col) >= ROW_BYTES_W'(eff_pb));
    s1_top         <= (row_pos == '0);
    s1_last        <= row_done;
    s1_pend_sel    <= pend_sel;
    s1_above_sel   <= above_sel;
    s1_res_left_ok <= (ROW_BYTES_W'(e_idx) >= ROW_BYTES_W'(eff_pb));
    s1_res_top     <= pend_top;
    s1_res_end     <= e_end;
  end

  // cost accumulation
  logic [7:0]        uhist [MAX_PIXEL_BYTES];
  logic [7:0]        c_u;
  logic [7:0]        c_ul;
  logic [COST_W-1:0] sums [FILTER_COUNT];
  logic [COST_W-1:0] sums_add [FILTER_COUNT];
  filt_t             best;

  always_comb begin
    logic [COST_W:0]   s;
    logic [COST_W-1:0] bsum;
    c_u  = s1_top ? 8'd0 : rd_a[s1_pend_sel];
    c_ul = (s1_top || !s1_left_ok) ? 8'd0 : uhist[pbi];
    for (int k = 0; k < FILTER_COUNT; k++) begin
      s = {1'b0, sums[k]} +
          (COST_W+1)'(abs_diff(s1_x, predict(filt_t'(3'(k)), s1_l, c_u, c_ul)));
      sums_add[k] = s[COST_W] ? COST_MAX : s[COST_W-1:0];
    end
    best = FILT_NONE;
    bsum = sums_add[0];
    for (int k = 1; k < FILTER_COUNT; k++) begin
      if (sums_add[k] < bsum) begin
        bsum = sums_add[k];
        best = filt_t'(3'(k));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < FILTER_COUNT; k++) begin
        sums[k] <= '0;
      end
      pend_type <= FILT_NONE;
    end else if (s1_data) begin
      for (int k = 0; k < FILTER_COUNT; k++) begin
        sums[k] <= s1_last ? '0 : sums_add[k];
      end
      if (s1_last) begin
        pend_type <= best;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_data) begin
      uhist[0] <= c_u;
      for (int j = 1; j < MAX_PIXEL_BYTES; j++) begin
        uhist[j] <= uhist[j-1];
      end
    end
  end

  // residual of the pending row
  logic [7:0] phist [MAX_PIXEL_BYTES];
  logic [7:0] ahist [MAX_PIXEL_BYTES];
  logic [7:0] r_x;
  logic [7:0] r_l;
  logic [7:0] r_u;
  logic [7:0] r_ul;
  logic [7:0] r_val;

  assign r_x   = rd_b[s1_pend_sel];
  assign r_l   = s1_res_left_ok ? phist[pbi] : 8'd0;
  assign r_u   = s1_res_top ? 8'd0 : rd_b[s1_above_sel];
  assign r_ul  = (s1_res_top || !s1_res_left_ok) ? 8'd0 : ahist[pbi];
  assign r_val = r_x - predict(pend_type, r_l, r_u, r_ul);

  always_ff @(posedge clk) begin
    if (s1_res) begin
      phist[0] <= r_x;
      ahist[0] <= r_u;
      for (int j = 1; j < MAX_PIXEL_BYTES; j++) begin
        phist[j] <= phist[j-1];
        ahist[j] <= ahist[j-1];
      end
    end
  end

  push_t     push;
  out_item_t type_item;
  out_item_t res_item;

  always_comb begin
    type_item = '{out_byte: 8'(pend_type), is_type_byte: 1'b1, row_end: 1'b0};
    res_item  = '{out_byte: r_val, is_type_byte: 1'b0, row_end: s1_res_end};
    push.v0 = s1_type | s1_res;
    push.v1 = s1_type & s1_res;
    push.e0 = s1_type ? type_item : res_item;
    push.e1 = res_item;
  end

  par_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .count      (q_count),
    .result_out (result_out)
  );

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    (QUEUE_CNT_W'(q_count) <= QUEUE_CNT_W'(QUEUE_DEPTH)))
    else $error("result queue overflow");

  a_idle_pos: assert property (@(posedge clk) disable iff (rst)
    !pend_valid |-> (emit_pos == '0))
    else $error("emit position set with no pending row");

  a_rot_range: assert property (@(posedge clk) disable iff (rst)
    (rot != 2'd3))
    else $error("store rotation out of range");

  a_type_alone: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && result_out.data.is_type_byte) |-> !result_out.data.row_end)
    else $error("type byte flagged as row end");

  a_two_needs_pixel: assert property (@(posedge clk) disable iff (rst)
    (s1_type && s1_res) |-> s1_data)
    else $error("two results from a drain");

endmodule

`default_nettype wire

@@ hw/rtl/par_ram.sv @@
// ----------------------------------------------------------------------------
// par_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module par_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output      logic [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output      logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

@@ hw/rtl/par_queue.sv @@
// ----------------------------------------------------------------------------
// par_queue
// Result queue: takes up to two entries a cycle, hands out one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module par_queue import par_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire push_t              push,
  output      logic [QUEUE_CNT_W-1:0] count,
  par_out_if.source               result_out
);

  out_item_t              mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] head;
  logic [QUEUE_PTR_W-1:0] tail;
  logic                   pop;
  logic [QUEUE_CNT_W-1:0] n_push;

  assign result_out.valid = (count != '0);
  assign result_out.data  = mem[head];
  assign pop    = result_out.valid & result_out.ready;
  assign n_push = QUEUE_CNT_W'(push.v0) + QUEUE_CNT_W'(push.v1);

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[tail] <= push.e0;
    end
    if (push.v1) begin
      mem[tail + QUEUE_PTR_W'(1)] <= push.e1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + n_push[QUEUE_PTR_W-1:0];
      head  <= head + QUEUE_PTR_W'(pop);
      count <= count + n_push - QUEUE_CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire
